[sv/scitp_pkg.sv]
package scitp_pkg;

    localparam logic [1:0] OP_PUSH      = 2'd0;
    localparam logic [1:0] OP_PUSH_LAST = 2'd1;
    localparam logic [1:0] OP_FLUSH     = 2'd2;
    localparam logic [1:0] OP_POP       = 2'd3;

    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_HOLD   = 2'd1;
    localparam logic [1:0] MODE_LINEAR = 2'd2;

    localparam logic [0:0] CFG_FILL_MODE   = 1'd0;
    localparam logic [0:0] CFG_FULL_HEIGHT = 1'd1;

    localparam logic [7:0] FULL_HEIGHT_RST = 8'd48;

    // status counters are carried at the width of the largest buffer
    localparam int STAT_W = 9;

    typedef struct packed {
        logic        push;
        logic        last;
        logic        flush;
        logic        pop;
        logic [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic [31:0] value;
        logic [6:0]  bin_index;
        logic        last_of_column;
        logic        empty_res;
        logic        overflowed;
    } t_res;

    typedef struct packed {
        logic [STAT_W-1:0] count;
        logic [STAT_W-1:0] released;
        logic              ovf;
    } t_stat;

endpackage

[sv/scitp_front.sv]
module scitp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tvalid,
    output logic             o_tready,
    input  logic [31:0]      i_tdata,
    input  logic [1:0]       i_tuser,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output scitp_pkg::t_cmd  o_cmd
);
    import scitp_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       dec;
    logic       wr, rd;

    // classify the incoming word
    always_comb begin
        dec       = '0;
        dec.value = i_tdata;
        unique case (i_tuser)
            OP_PUSH:      dec.push = 1'b1;
            OP_PUSH_LAST: begin
                dec.push = 1'b1;
                dec.last = 1'b1;
            end
            OP_FLUSH:     dec.flush = 1'b1;
            OP_POP:       dec.pop = 1'b1;
            default:      dec.pop = 1'b1;
        endcase
    end

    assign o_tready    = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign wr          = i_tvalid && o_tready;
    assign rd          = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            unique case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[sv/scitp_blend.sv]
module scitp_blend #(
    parameter int CNT_W = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_a,
    input  logic [31:0]        i_b,
    input  logic [CNT_W-1:0]   i_j,
    input  logic [CNT_W-1:0]   i_s,
    output logic               o_done,
    output logic [31:0]        o_q
);
    localparam int MUL_W = 32 + CNT_W + 1;
    localparam int NUM_W = MUL_W + 1;
    localparam int DV_W  = NUM_W + 1 + CNT_W + 2;
    localparam int DC_W  = $clog2(DV_W + 1);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_M1   = 3'd1;
    localparam logic [2:0] B_M2   = 3'd2;
    localparam logic [2:0] B_SUM  = 3'd3;
    localparam logic [2:0] B_DIV  = 3'd4;
    localparam logic [2:0] B_DONE = 3'd5;

    logic [2:0]              r_state;
    logic signed [31:0]      r_a, r_b;
    logic [CNT_W-1:0]        r_j, r_s;
    logic signed [MUL_W-1:0] r_p1, r_p2;
    logic [DV_W-1:0]         r_dvd;
    logic [CNT_W:0]          r_rem;
    logic [DC_W-1:0]         r_cnt;

    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W:0]   n2;
    logic [CNT_W:0]          dsr;
    logic [DV_W-1:0]         dvd0;
    logic [CNT_W+1:0]        rs;
    logic                    qbit;

    // floor((2*num + s) / 2s); offset the dividend by 2s << (NUM_W+1) to keep it positive,
    // which leaves the low 32 quotient bits untouched
    assign num  = NUM_W'(r_p1) + NUM_W'(r_p2);
    assign n2   = $signed({num, 1'b0}) + $signed({{(NUM_W + 1 - CNT_W){1'b0}}, r_s});
    assign dsr  = {r_s, 1'b0};
    assign dvd0 = $unsigned(DV_W'(n2)) + (DV_W'(dsr) << (NUM_W + 1));
    assign rs   = {r_rem, r_dvd[DV_W-1]};
    assign qbit = (rs >= {1'b0, dsr});

    assign o_done = (r_state == B_DONE);
    assign o_q    = r_dvd[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: if (i_start) r_state <= B_M1;
                B_M1:   r_state <= B_M2;
                B_M2:   r_state <= B_SUM;
                B_SUM:  r_state <= B_DIV;
                B_DIV:  if (r_cnt == DC_W'(DV_W - 1)) r_state <= B_DONE;
                B_DONE: r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_a <= $signed(i_a);
                r_b <= $signed(i_b);
                r_j <= i_j;
                r_s <= i_s;
            end
            B_M1: r_p1 <= r_a * $signed({1'b0, r_s - r_j});
            B_M2: r_p2 <= r_b * $signed({1'b0, r_j});
            B_SUM: begin
                r_dvd <= dvd0;
                r_rem <= '0;
                r_cnt <= '0;
            end
            B_DIV: begin
                r_rem <= qbit ? (CNT_W + 1)'(rs - {1'b0, dsr}) : (CNT_W + 1)'(rs);
                r_dvd <= {r_dvd[DV_W-2:0], qbit};
                r_cnt <= r_cnt + DC_W'(1);
            end
            default: r_cnt <= r_cnt;
        endcase
    end

endmodule

[sv/scitp_back.sv]
module scitp_back #(
    parameter int MAX_BINS    = 128,
    parameter int MAX_COLUMNS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  scitp_pkg::t_cmd   i_cmd,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output scitp_pkg::t_res   o_out,
    output scitp_pkg::t_stat  o_stat
);
    import scitp_pkg::*;

    localparam int BIN_W  = $clog2(MAX_BINS);
    localparam int SLOT_W = $clog2(MAX_COLUMNS);
    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int HGT_W  = $clog2(MAX_BINS + 1);
    localparam int ADR_W  = SLOT_W + BIN_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POP   = 4'd1;
    localparam logic [3:0] S_HLDA  = 4'd2;
    localparam logic [3:0] S_HLDB  = 4'd3;
    localparam logic [3:0] S_SCANA = 4'd4;
    localparam logic [3:0] S_SCANB = 4'd5;
    localparam logic [3:0] S_FY    = 4'd6;
    localparam logic [3:0] S_FYW   = 4'd7;
    localparam logic [3:0] S_FKA   = 4'd8;
    localparam logic [3:0] S_FKB   = 4'd9;
    localparam logic [3:0] S_BLGO  = 4'd10;
    localparam logic [3:0] S_BLW   = 4'd11;
    localparam logic [3:0] S_FHA   = 4'd12;
    localparam logic [3:0] S_FHB   = 4'd13;

    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [CNT_W-1:0] ofs);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(ofs);
        if (sum >= (CNT_W + 1)'(MAX_COLUMNS)) begin
            sum = sum - (CNT_W + 1)'(MAX_COLUMNS);
        end
        return SLOT_W'(sum);
    endfunction

    logic [31:0]      mem_store  [2**ADR_W];
    logic [HGT_W-1:0] mem_height [MAX_COLUMNS];
    logic [31:0]      mem_held   [MAX_BINS];

    logic [3:0]        r_state, n_state;
    logic [1:0]        r_mode;
    logic [7:0]        r_fh;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count, r_rel, n_rel;
    logic [HGT_W-1:0]  r_fill, n_fill;
    logic [BIN_W-1:0]  r_pop, n_pop;
    logic              r_ovf, n_ovf, r_drop, n_drop;
    logic [HGT_W-1:0]  r_hheld, n_hheld;
    logic [SLOT_W-1:0] r_cslot, n_cslot;
    logic [HGT_W-1:0]  r_chgt, n_chgt, r_hnew, n_hnew, r_j, n_j, r_y, n_y;
    logic [CNT_W-1:0]  r_p, n_p, r_p0, n_p0, r_p1, n_p1;
    logic [CNT_W-1:0]  r_k, n_k, r_l, n_l, r_m, n_m;
    logic              r_have, n_have;
    logic [31:0]       r_a, n_a, r_b, n_b;
    logic              r_out_valid, n_out_valid;
    t_res              r_out, n_out;

    logic              st_we, hg_we, hd_we;
    logic [ADR_W-1:0]  st_wa, st_ra;
    logic [31:0]       st_wd, st_q, hd_wd, hd_q;
    logic [SLOT_W-1:0] hg_wa, hg_ra;
    logic [HGT_W-1:0]  hg_wd, hg_q;
    logic [BIN_W-1:0]  hd_a;

    logic              drop, adv, out_free, bl_start, bl_done, last_b;
    logic [HGT_W-1:0]  fill_nx, eff;
    logic [SLOT_W-1:0] slot_cnt;
    logic [CNT_W-1:0]  span_w;
    logic [31:0]       bl_q, hold_val;

    assign eff = (32'(r_fh) > 32'(MAX_BINS)) ? HGT_W'(MAX_BINS) : HGT_W'(r_fh);
    assign slot_cnt = slot_add(r_head, r_count);
    assign span_w   = r_p1 - r_p0;
    assign out_free = !r_out_valid || i_out_ready;
    assign hd_a     = r_j[BIN_W-1:0];
    assign last_b   = (HGT_W'(r_pop) + HGT_W'(1)) >= hg_q;

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            mem_store[st_wa] <= st_wd;
        end
        st_q <= mem_store[st_ra];
    end

    always_ff @(posedge i_clk) begin
        if (hg_we) begin
            mem_height[hg_wa] <= hg_wd;
        end
        hg_q <= mem_height[hg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (hd_we) begin
            mem_held[hd_a] <= hd_wd;
        end
        hd_q <= mem_held[hd_a];
    end

    scitp_blend #(
        .CNT_W (CNT_W)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bl_start),
        .i_a     (r_a),
        .i_b     (r_b),
        .i_j     (r_m - r_l),
        .i_s     (r_k - r_l),
        .o_done  (bl_done),
        .o_q     (bl_q)
    );

    always_comb begin
        n_state = r_state;  n_head = r_head;   n_count = r_count; n_rel = r_rel;
        n_fill = r_fill;    n_pop = r_pop;     n_ovf = r_ovf;     n_drop = r_drop;
        n_hheld = r_hheld;  n_cslot = r_cslot; n_chgt = r_chgt;   n_hnew = r_hnew;
        n_j = r_j;          n_y = r_y;         n_p = r_p;         n_p0 = r_p0;
        n_p1 = r_p1;        n_k = r_k;         n_l = r_l;         n_m = r_m;
        n_have = r_have;    n_a = r_a;         n_b = r_b;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out = r_out;
        st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = {r_head, r_pop};
        hg_we = 1'b0; hg_wa = '0; hg_wd = '0; hg_ra = r_head;
        hd_we = 1'b0; hd_wd = '0;
        bl_start = 1'b0; adv = 1'b0; o_cmd_ready = 1'b0;
        drop = r_drop; fill_nx = r_fill; hold_val = '0;

        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = !i_cmd.pop || out_free;
                if (i_cmd_valid && o_cmd_ready) begin
                    priority if (i_cmd.push) begin
                        drop   = r_drop || (r_count >= CNT_W'(MAX_COLUMNS));
                        n_drop = drop;
                        if (!drop && r_fill < HGT_W'(MAX_BINS)) begin
                            st_we   = 1'b1;
                            st_wa   = {slot_cnt, r_fill[BIN_W-1:0]};
                            st_wd   = i_cmd.value;
                            fill_nx = r_fill + HGT_W'(1);
                        end
                        n_fill = fill_nx;
                        if (i_cmd.last) begin
                            n_fill = '0;
                            if (drop) begin
                                n_ovf  = 1'b1;
                                n_drop = 1'b0;
                            end else begin
                                hg_we   = 1'b1;
                                hg_wa   = slot_cnt;
                                hg_wd   = fill_nx;
                                n_count = r_count + CNT_W'(1);
                                if (r_mode == MODE_LINEAR) begin
                                    n_p     = r_rel;
                                    n_have  = 1'b0;
                                    n_state = S_SCANA;
                                end else if (r_mode == MODE_HOLD) begin
                                    n_cslot = slot_cnt;
                                    n_chgt  = fill_nx;
                                    n_hnew  = (eff > fill_nx) ? eff : fill_nx;
                                    n_j     = '0;
                                    n_state = S_HLDA;
                                end else begin
                                    n_rel = r_count + CNT_W'(1);
                                end
                            end
                        end
                    end else if (i_cmd.flush) begin
                        n_rel = r_count;
                    end else begin
                        if (r_rel == '0) begin
                            n_out_valid = 1'b1;
                            n_out       = '0;
                            n_out.empty_res  = 1'b1;
                            n_out.overflowed = r_ovf;
                        end else begin
                            n_state = S_POP;
                        end
                    end
                end
            end
            S_POP: begin
                n_out_valid          = 1'b1;
                n_out.value          = st_q;
                n_out.bin_index      = 7'(r_pop);
                n_out.last_of_column = last_b;
                n_out.empty_res      = 1'b0;
                n_out.overflowed     = r_ovf;
                if (last_b) begin
                    n_pop   = '0;
                    n_head  = slot_add(r_head, CNT_W'(1));
                    n_count = r_count - CNT_W'(1);
                    n_rel   = r_rel - CNT_W'(1);
                end else begin
                    n_pop = r_pop + BIN_W'(1);
                end
                n_state = S_IDLE;
            end
            S_HLDA: begin
                st_ra   = {r_cslot, r_j[BIN_W-1:0]};
                n_state = S_HLDB;
            end
            S_HLDB: begin
                // copy pushed bins into the hold buffer, fill the rest from it
                if (r_j < r_chgt) begin
                    hold_val = st_q;
                end else begin
                    hold_val = (r_j < r_hheld) ? hd_q : 32'd0;
                    st_we    = 1'b1;
                    st_wa    = {r_cslot, r_j[BIN_W-1:0]};
                    st_wd    = hold_val;
                end
                hd_we = 1'b1;
                hd_wd = hold_val;
                if (r_j + HGT_W'(1) == r_hnew) begin
                    hg_we   = 1'b1;
                    hg_wa   = r_cslot;
                    hg_wd   = r_hnew;
                    n_hheld = r_hnew;
                    n_rel   = r_count;
                    n_state = S_IDLE;
                end else begin
                    n_j     = r_j + HGT_W'(1);
                    n_state = S_HLDA;
                end
            end
            S_SCANA: begin
                if (r_p == r_count) begin
                    n_state = S_IDLE;
                end else begin
                    hg_ra   = slot_add(r_head, r_p);
                    n_state = S_SCANB;
                end
            end
            S_SCANB: begin
                if (hg_q == eff) begin
                    if (!r_have) begin
                        // release short columns ahead of the first full one
                        n_have  = 1'b1;
                        n_rel   = r_p;
                        n_p     = r_p + CNT_W'(1);
                        n_state = S_SCANA;
                    end else begin
                        n_p0    = r_rel;
                        n_p1    = r_p;
                        n_y     = '0;
                        n_state = S_FY;
                    end
                end else begin
                    n_p     = r_p + CNT_W'(1);
                    n_state = S_SCANA;
                end
            end
            S_FY: begin
                st_ra   = {slot_add(r_head, r_p0), r_y[BIN_W-1:0]};
                n_state = S_FYW;
            end
            S_FYW: begin
                n_a     = st_q;
                n_l     = '0;
                n_k     = CNT_W'(1);
                n_state = S_FKA;
            end
            S_FKA: begin
                hg_ra   = slot_add(r_head, CNT_W'(r_p0 + r_k));
                st_ra   = {hg_ra, r_y[BIN_W-1:0]};
                n_state = S_FKB;
            end
            S_FKB: begin
                if (hg_q > r_y) begin
                    n_b = st_q;
                    if (r_k > r_l + CNT_W'(1)) begin
                        n_m     = r_l + CNT_W'(1);
                        n_state = S_BLGO;
                    end else begin
                        n_l = r_k;
                        n_a = st_q;
                        adv = 1'b1;
                    end
                end else begin
                    adv = 1'b1;
                end
            end
            S_BLGO: begin
                bl_start = 1'b1;
                n_state  = S_BLW;
            end
            S_BLW: begin
                if (bl_done) begin
                    st_we = 1'b1;
                    st_wa = {slot_add(r_head, CNT_W'(r_p0 + r_m)), r_y[BIN_W-1:0]};
                    st_wd = bl_q;
                    if (r_m + CNT_W'(1) == r_k) begin
                        n_l = r_k;
                        n_a = r_b;
                        adv = 1'b1;
                    end else begin
                        n_m     = r_m + CNT_W'(1);
                        n_state = S_BLGO;
                    end
                end
            end
            S_FHA: begin
                if (r_k >= span_w) begin
                    n_rel   = r_p1;
                    n_p     = r_p1 + CNT_W'(1);
                    n_have  = 1'b1;
                    n_state = S_SCANA;
                end else begin
                    hg_ra   = slot_add(r_head, CNT_W'(r_p0 + r_k));
                    n_state = S_FHB;
                end
            end
            S_FHB: begin
                if (hg_q < eff) begin
                    hg_we = 1'b1;
                    hg_wa = slot_add(r_head, CNT_W'(r_p0 + r_k));
                    hg_wd = eff;
                end
                n_k     = r_k + CNT_W'(1);
                n_state = S_FHA;
            end
            default: n_state = S_IDLE;
        endcase

        // step to the next column of the span, then the next bin row
        if (adv) begin
            if (r_k == span_w) begin
                if (r_y + HGT_W'(1) == eff) begin
                    n_k     = CNT_W'(1);
                    n_state = S_FHA;
                end else begin
                    n_y     = r_y + HGT_W'(1);
                    n_state = S_FY;
                end
            end else begin
                n_k     = r_k + CNT_W'(1);
                n_state = S_FKA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_PASS;
            r_fh        <= FULL_HEIGHT_RST;
            r_head      <= '0;
            r_count     <= '0;
            r_rel       <= '0;
            r_fill      <= '0;
            r_pop       <= '0;
            r_ovf       <= 1'b0;
            r_drop      <= 1'b0;
            r_hheld     <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rel       <= n_rel;
            r_fill      <= n_fill;
            r_pop       <= n_pop;
            r_ovf       <= n_ovf;
            r_drop      <= n_drop;
            r_hheld     <= n_hheld;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FILL_MODE:   r_mode <= i_cfg_data[1:0];
                    CFG_FULL_HEIGHT: r_fh   <= i_cfg_data;
                    default:         r_mode <= r_mode;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cslot <= n_cslot;
        r_chgt  <= n_chgt;
        r_hnew  <= n_hnew;
        r_j     <= n_j;
        r_y     <= n_y;
        r_p     <= n_p;
        r_p0    <= n_p0;
        r_p1    <= n_p1;
        r_k     <= n_k;
        r_l     <= n_l;
        r_m     <= n_m;
        r_a     <= n_a;
        r_b     <= n_b;
        r_out   <= n_out;
    end

    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;
    assign o_stat.count    = STAT_W'(r_count);
    assign o_stat.released = STAT_W'(r_rel);
    assign o_stat.ovf      = r_ovf;

endmodule

[sv/sparse_column_interpolator.sv]
// Sparse column interpolator. Words on the slave side carry an opcode in tuser (push bin,
// push last bin of a column, flush, pop) and a signed Q16.16 bin value in tdata. Closed columns
// go into a ring buffer of MAX_COLUMNS columns of MAX_BINS bins and are filled to full height
// by fill_mode: pass-through, hold (missing bins repeat the previous filled column, zero where
// it has none) or linear (columns wait until the next full-height column, then missing bins
// are interpolated, rounded to nearest). Only a pop returns a word on the master side: one bin
// value, its index, tlast on the final bin of a column, and tuser flags for "nothing to pop"
// and the sticky buffer-overflow flag. A two-word queue decouples the slave side from the
// sequencer, and a result register decouples the master side. Push and flush are taken in the
// idle state; a pop also passes a store read state. Closing a column in hold mode reads, then
// copies each bin; in linear mode the sequencer scans the buffered columns for full ones, then
// walks each column of each span per bin row, and each interpolated bin passes through the
// shared blend unit (two multiplies, then a restoring divider at one quotient bit per cycle).
// No clearing pass is needed after reset. Write configuration only while the block is idle.
module sparse_column_interpolator #(
    parameter int MAX_BINS    = 128,
    parameter int MAX_COLUMNS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] sample_value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] value, [38:32] bin_index, [39] zero
    output logic        o_m_axis_tlast,   // last_of_column
    output logic [1:0]  o_m_axis_tuser,   // [0] empty_res, [1] overflowed
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import scitp_pkg::*;

    logic  cmd_valid, cmd_ready;
    t_cmd  cmd;
    t_res  res;
    t_stat stat;

    // accept and classify words, hold up to two ahead of the sequencer
    scitp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (i_s_axis_tvalid),
        .o_tready    (o_s_axis_tready),
        .i_tdata     (i_s_axis_tdata),
        .i_tuser     (i_s_axis_tuser),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // store columns, run the fill modes, drive the result register
    scitp_back #(
        .MAX_BINS    (MAX_BINS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out       (res),
        .o_stat      (stat)
    );

    assign o_m_axis_tdata = {1'b0, res.bin_index, res.value};
    assign o_m_axis_tlast = res.last_of_column;
    assign o_m_axis_tuser = {res.overflowed, res.empty_res};

    // released columns are always a prefix of the stored ones
    a_rel_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.released <= stat.count)
        else $error("released count exceeds stored count");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= STAT_W'(MAX_COLUMNS))
        else $error("stored count beyond buffer size");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.ovf |=> stat.ovf)
        else $error("overflow flag cleared");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0 && !o_m_axis_tlast))
        else $error("empty result carries data");

endmodule
